// ===== rtl/uri_enc_pkg.sv =====
// Package: shared types, character constants and classification functions.
package uri_enc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_RSET   = 2'd1;

  // Reserved character sets
  typedef enum logic [1:0] {
    RSET_USER = 2'd0,
    RSET_HOST = 2'd1,
    RSET_PATH = 2'd2,
    RSET_NONE = 2'd3
  } rset_t;

  localparam logic [15:0] CH_PCT = 16'h0025;

  // One result item
  typedef struct packed {
    logic [15:0] ch;
    logic        last;
    logic        bad;
  } res_t;

  // Result group produced by one input item
  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] res;
  } grp_t;

  // Scanner state carried between items
  typedef struct packed {
    logic [1:0] hex_pending;
    logic       drop_rest;
  } scan_t;

  function automatic logic is_subdelim(input logic [15:0] c);
    is_subdelim = c inside {16'h21, 16'h24, 16'h26, 16'h27, 16'h28, 16'h29,
                            16'h2A, 16'h2B, 16'h2C, 16'h3B, 16'h3D};
  endfunction

  function automatic logic is_hex(input logic [15:0] c);
    is_hex = c inside {[16'h30:16'h39], [16'h41:16'h46], [16'h61:16'h66]};
  endfunction

  function automatic logic passes(input logic [15:0] c, input rset_t rset);
    logic base;
    logic rsv;
    base = (c >= 16'h0080) ||
           (c inside {[16'h30:16'h39], [16'h41:16'h5A], [16'h61:16'h7A],
                      16'h2D, 16'h2E, 16'h5F, 16'h7E});
    case (rset)
      RSET_USER: rsv = is_subdelim(c) || (c == 16'h3A);
      RSET_HOST: rsv = is_subdelim(c);
      RSET_PATH: rsv = is_subdelim(c) || (c inside {16'h2F, 16'h3A, 16'h40});
      default:   rsv = 1'b0;
    endcase
    passes = base || rsv;
  endfunction

  // Uppercase hex digit for one nibble
  function automatic logic [15:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_char = 16'h0030 + {12'd0, n};
    end else begin
      hex_char = 16'h0037 + {12'd0, n};
    end
  endfunction

endpackage

// ===== rtl/uri_enc_step.sv =====
// Combinational step: classify one character and build its result group.
module uri_enc_step (
  input  logic [15:0]          char_i,
  input  logic                 last_i,
  input  uri_enc_pkg::scan_t   scan_i,
  input  logic                 enable_i,
  input  uri_enc_pkg::rset_t   rset_i,
  output uri_enc_pkg::scan_t   scan_o,
  output uri_enc_pkg::grp_t    grp_o
);

  uri_enc_pkg::res_t fail_res;
  uri_enc_pkg::res_t pass_res;

  assign fail_res = '{ch: 16'd0, last: 1'b1, bad: 1'b1};
  assign pass_res = '{ch: char_i, last: last_i, bad: 1'b0};

  always_comb begin
    scan_o = scan_i;
    grp_o  = '0;
    if (scan_i.drop_rest) begin
      // drop until the end of the component
      if (last_i) begin
        scan_o.drop_rest = 1'b0;
      end
    end else if (scan_i.hex_pending == 2'd2) begin
      // first escape digit: must be hex and not the end
      grp_o.cnt = 2'd1;
      if (last_i || !uri_enc_pkg::is_hex(char_i)) begin
        grp_o.res[0]       = fail_res;
        scan_o.hex_pending = 2'd0;
        scan_o.drop_rest   = !last_i;
      end else begin
        grp_o.res[0]       = '{ch: char_i, last: 1'b0, bad: 1'b0};
        scan_o.hex_pending = 2'd1;
      end
    end else if (scan_i.hex_pending != 2'd0) begin
      // second escape digit
      grp_o.cnt          = 2'd1;
      scan_o.hex_pending = 2'd0;
      if (!uri_enc_pkg::is_hex(char_i)) begin
        grp_o.res[0]     = fail_res;
        scan_o.drop_rest = !last_i;
      end else begin
        grp_o.res[0] = pass_res;
      end
    end else if (!enable_i || uri_enc_pkg::passes(char_i, rset_i)) begin
      grp_o.cnt    = 2'd1;
      grp_o.res[0] = pass_res;
    end else if (char_i == uri_enc_pkg::CH_PCT) begin
      // open an escape
      grp_o.cnt = 2'd1;
      if (last_i) begin
        grp_o.res[0] = fail_res;
      end else begin
        grp_o.res[0]       = '{ch: uri_enc_pkg::CH_PCT, last: 1'b0, bad: 1'b0};
        scan_o.hex_pending = 2'd2;
      end
    end else begin
      // encode as %XY
      grp_o.cnt    = 2'd3;
      grp_o.res[0] = '{ch: uri_enc_pkg::CH_PCT, last: 1'b0, bad: 1'b0};
      grp_o.res[1] = '{ch: uri_enc_pkg::hex_char(char_i[7:4]), last: 1'b0, bad: 1'b0};
      grp_o.res[2] = '{ch: uri_enc_pkg::hex_char(char_i[3:0]), last: last_i, bad: 1'b0};
    end
  end

endmodule

// ===== rtl/uri_percent_encoder.sv =====
// Top level: percent-encoder for one URI component, one code unit per transaction.
// The input register holds each accepted item; the step logic builds its result group,
// which the group register loads once it is empty or its last result drains; results leave
// one at a time through the single result port from that three-entry group register.
// Reset: synchronous active-low rst_n clears the escape and drop state, empties
// both register stages and loads encode_enable = 1, reserved_set = path.
module uri_percent_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_char_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char_out,
  output logic        out_last_out,
  output logic        out_bad_escape,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic                 enable_r;
  uri_enc_pkg::rset_t   rset_r;
  uri_enc_pkg::scan_t   scan_r, scan_nxt;
  logic                 in_vld_r, in_vld_nxt;
  logic [15:0]          in_char_r;
  logic                 in_last_r;
  uri_enc_pkg::grp_t    grp_r, grp_nxt;
  uri_enc_pkg::grp_t    step_grp;
  uri_enc_pkg::scan_t   step_scan;
  logic                 in_acc, out_acc, load_ok, proc;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      rset_r   <= uri_enc_pkg::RSET_PATH;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == uri_enc_pkg::CFG_ENABLE) begin
        enable_r <= cfg_data[0];
      end else if (cfg_index == uri_enc_pkg::CFG_RSET) begin
        rset_r <= uri_enc_pkg::rset_t'(cfg_data);
      end
    end
  end

  // Handshakes: the group register takes a new group once it drains this cycle
  assign out_valid = (grp_r.cnt != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign load_ok   = (grp_r.cnt == 2'd0) || ((grp_r.cnt == 2'd1) && !out_stall);
  assign in_stall  = in_vld_r && !load_ok;
  assign in_acc    = in_valid && !in_stall;
  assign proc      = in_vld_r && load_ok;

  uri_enc_step u_step (
    .char_i   (in_char_r),
    .last_i   (in_last_r),
    .scan_i   (scan_r),
    .enable_i (enable_r),
    .rset_i   (rset_r),
    .scan_o   (step_scan),
    .grp_o    (step_grp)
  );

  // Next state of the input stage, scanner and group register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end

    scan_nxt = proc ? step_scan : scan_r;

    grp_nxt = grp_r;
    if (out_acc) begin
      grp_nxt.cnt    = grp_r.cnt - 2'd1;
      grp_nxt.res[0] = grp_r.res[1];
      grp_nxt.res[1] = grp_r.res[2];
    end
    if (proc && (step_grp.cnt != 2'd0)) begin
      grp_nxt = step_grp;
    end
  end

  // Hold control state and the result group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      scan_r   <= '0;
      grp_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      scan_r   <= scan_nxt;
      grp_r    <= grp_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_char_r <= in_char_in;
      in_last_r <= in_last_in;
    end
  end

  assign out_char_out   = grp_r.res[0].ch;
  assign out_last_out   = grp_r.res[0].last;
  assign out_bad_escape = grp_r.res[0].bad;

  // Checks
  a_no_pending_three: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.hex_pending != 2'd3)
    else $error("hex_pending reached an unused code");

  a_drop_excl_escape: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_r.drop_rest && (scan_r.hex_pending != 2'd0)))
    else $error("drop and open escape both set");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_escape) |-> (out_last_out && (grp_r.cnt == 2'd1)))
    else $error("error result not the final result of its group");

  a_proc_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (step_grp.cnt != 2'd0)) |=> (grp_r.cnt == $past(step_grp.cnt)))
    else $error("result group not loaded");

endmodule
